// File: sv/positional_deque_defines.svh
// ----------------------------------------------------------------------------
// Positional deque assertion macros
// Shared macros for the concurrent checks on the positional deque ports.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_DEQUE_DEFINES_SVH
`define POSITIONAL_DEQUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define PDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_deque check failed");

`endif

// File: sv/pdq_pkg.sv
// ----------------------------------------------------------------------------
// Positional deque package
// Sizes, operation and status codes, and the control word sent to the cells.
// ----------------------------------------------------------------------------
package pdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_INSERT_AT  = 3'd4;
    localparam logic [2:0] OP_REMOVE_AT  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOPOS = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] value;
    } pdq_ctrl_t;

endpackage

// File: sv/positional_deque.sv
// ----------------------------------------------------------------------------
// Positional deque
// Bounded ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// For each operation, at the input transfer the cells from the chosen index
// onward shift by one place, and in the next cycle the result register loads
// the front, back, count and status from the updated row. A new operation is
// accepted once no operation is pending and the result register is empty or
// its result is leaving, so an operation is not accepted before the result of
// the last one is loaded. Cells beyond the count always hold zero.
module positional_deque (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic [4:0]         element_count,
    output logic [1:0]         status
);

    localparam int D = pdq_pkg::DEPTH;

    logic signed [31:0]          cell_data [D];
    logic signed [31:0]          left_in   [D];
    logic signed [31:0]          right_in  [D];
    pdq_pkg::pdq_ctrl_t          op_ctrl;
    pdq_pkg::pdq_ctrl_t          cell_ctrl;
    logic                        in_xfer;
    logic                        full;
    logic                        empty;
    logic                        pos_ok;
    logic [pdq_pkg::CMP_W-1:0]   pos_ext;
    logic [pdq_pkg::CMP_W-1:0]   cnt_ext;
    logic [pdq_pkg::CNT_W-1:0]   count_reg;
    logic [pdq_pkg::CNT_W-1:0]   count_next;
    logic [1:0]                  st_next;
    logic [1:0]                  st_hold_reg;
    logic                        pending_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [31:0]          front_reg;
    logic signed [31:0]          back_reg;
    logic [4:0]                  ecount_reg;
    logic [1:0]                  status_reg;
    logic [pdq_pkg::IDX_W-1:0]   back_idx;

    assign in_ready = !pending_reg && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;

    assign full    = (count_reg == pdq_pkg::CNT_W'(D));
    assign empty   = (count_reg == '0);
    assign pos_ext = pdq_pkg::CMP_W'(position);
    assign cnt_ext = pdq_pkg::CMP_W'(count_reg);
    assign pos_ok  = (position != 5'd0) && (pos_ext <= cnt_ext);

    always_comb
    begin
        op_ctrl.ins   = 1'b0;
        op_ctrl.rem   = 1'b0;
        op_ctrl.idx   = '0;
        op_ctrl.value = value;
        st_next       = pdq_pkg::ST_OK;
        count_next    = count_reg;
        case (opcode)
            pdq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    st_next = pdq_pkg::ST_FULL;
                end
                else
                begin
                    op_ctrl.ins = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            pdq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    st_next = pdq_pkg::ST_FULL;
                end
                else
                begin
                    op_ctrl.ins = 1'b1;
                    op_ctrl.idx = pdq_pkg::IDX_W'(count_reg);
                    count_next  = count_reg + 1'b1;
                end
            end
            pdq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    st_next = pdq_pkg::ST_EMPTY;
                end
                else
                begin
                    op_ctrl.rem = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            pdq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    st_next = pdq_pkg::ST_EMPTY;
                end
                else
                begin
                    op_ctrl.rem = 1'b1;
                    op_ctrl.idx = pdq_pkg::IDX_W'(count_reg - 1'b1);
                    count_next  = count_reg - 1'b1;
                end
            end
            pdq_pkg::OP_INSERT_AT:
            begin
                if (!pos_ok)
                begin
                    st_next = pdq_pkg::ST_NOPOS;
                end
                else if (full)
                begin
                    st_next = pdq_pkg::ST_FULL;
                end
                else
                begin
                    op_ctrl.ins = 1'b1;
                    op_ctrl.idx = pdq_pkg::IDX_W'(position - 5'd1);
                    count_next  = count_reg + 1'b1;
                end
            end
            pdq_pkg::OP_REMOVE_AT:
            begin
                if (!pos_ok)
                begin
                    st_next = pdq_pkg::ST_NOPOS;
                end
                else
                begin
                    op_ctrl.rem = 1'b1;
                    op_ctrl.idx = pdq_pkg::IDX_W'(position - 5'd1);
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                st_next = pdq_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl     = op_ctrl;
        cell_ctrl.ins = op_ctrl.ins && in_xfer;
        cell_ctrl.rem = op_ctrl.rem && in_xfer;
    end

    for (genvar g = 0; g < D; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_in[g] = '0;
        end
        else
        begin : g_mid_l
            assign left_in[g] = cell_data[g-1];
        end
        if (g == D - 1)
        begin : g_last
            assign right_in[g] = '0;
        end
        else
        begin : g_mid_r
            assign right_in[g] = cell_data[g+1];
        end

        pdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (pdq_pkg::IDX_W'(g)),
            .ctrl       (cell_ctrl),
            .left_data  (left_in[g]),
            .right_data (right_in[g]),
            .data       (cell_data[g])
        );
    end

    assign back_idx = pdq_pkg::IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pending_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                count_reg <= count_next;
            end
            pending_reg   <= in_xfer;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            st_hold_reg <= st_next;
        end
        if (pending_reg)
        begin
            front_reg  <= empty ? 32'sd0 : cell_data[0];
            back_reg   <= empty ? 32'sd0 : cell_data[back_idx];
            ecount_reg <= cnt_ext[4:0];
            status_reg <= st_hold_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign front_value   = front_reg;
    assign back_value    = back_reg;
    assign element_count = ecount_reg;
    assign status        = status_reg;

endmodule

// File: sv/pdq_cell.sv
// ----------------------------------------------------------------------------
// Positional deque cell
// One list slot; on an insert or remove it takes the value of a neighbor or, at the insert index, the new value.
// ----------------------------------------------------------------------------
module pdq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pdq_pkg::IDX_W-1:0] cell_idx,
    input  pdq_pkg::pdq_ctrl_t        ctrl,
    input  logic signed [31:0]        left_data,
    input  logic signed [31:0]        right_data,
    output logic signed [31:0]        data
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (cell_idx > ctrl.idx)
            begin
                data_next = left_data;
            end
            else if (cell_idx == ctrl.idx)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.rem)
        begin
            if (cell_idx >= ctrl.idx)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// File: sv/pdq_checker.sv
// ----------------------------------------------------------------------------
// Positional deque checker
// Port-level checks on the positional deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_deque_defines.svh"

module pdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         opcode,
    input logic [4:0]         position,
    input logic signed [31:0] value,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] front_value,
    input logic signed [31:0] back_value,
    input logic [4:0]         element_count,
    input logic [1:0]         status
);

    `PDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PDQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready)
    `PDQ_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && (element_count == 5'd0), (front_value == 32'sd0) && (back_value == 32'sd0))
    `PDQ_ASSERT_NOW(a_single_same, clk, rst_n, out_valid && (element_count == 5'd1), front_value == back_value)
    `PDQ_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (status == pdq_pkg::ST_FULL), element_count == 5'(pdq_pkg::DEPTH))

endmodule

bind positional_deque pdq_checker u_pdq_checker (.*);
